FILE: hdl/alce_pkg.sv
// Shared types, codes and defaults for the associative cache with LRU eviction.
package alce_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  // Depth of the request queue between front and back; a power of two.
  localparam int QDEPTH = 2;
  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [2:0] KIND_SET      = 3'd0;
  localparam logic [2:0] KIND_GET      = 3'd1;
  localparam logic [2:0] KIND_SET_WAIT = 3'd2;
  localparam logic [2:0] KIND_GET_WAIT = 3'd3;
  localparam logic [2:0] KIND_REMOVE   = 3'd4;
  localparam logic [2:0] KIND_CLEAR    = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] key_tag;
    logic [31:0] handle_in;
    logic        wait_in;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] handle_out;
    logic        wait_out;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_SET,
    OP_GET,
    OP_SET_WAIT,
    OP_GET_WAIT,
    OP_REMOVE,
    OP_CLEAR,
    OP_NOP
  } op_code_t;

  typedef struct packed {
    op_code_t    code;
    logic [63:0] key;
    logic [31:0] handle;
    logic        wflag;
    logic [31:0] now;
    logic        upd_on_hit;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

endpackage

FILE: hdl/assoc_cache_lru_evict.sv
// Top level of the fully associative cache with least-recently-used eviction.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   alce_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall   alce_pkg::rsp_t
//
// In the back end an operation passes through LOOKUP for the tag match, then EXEC to update.
// A set that misses on a full table then scans slot times for the victim in SCAN,
// through the single read port of the time memory, and writes the victim in FILL.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// The request queue holds two operations, so requests are still taken while a result
// waits in the output register under rsp_stall, until the queue is full.
module assoc_cache_lru_evict #(
  parameter int ENTRIES = alce_pkg::ENTRIES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  alce_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output alce_pkg::rsp_t rsp
);
  import alce_pkg::*;

  head_t head;
  logic  pop;

  alce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .pop       (pop),
    .head      (head)
  );

  alce_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // A handle is returned only by a get that hit.
  a_handle_needs_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.handle_out != '0) |-> rsp.hit)
    else $error("handle returned without a hit");

  // A wait flag is returned only by a get_wait that hit, which carries no handle.
  a_wait_needs_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.wait_out |-> rsp.hit && (rsp.handle_out == '0))
    else $error("wait flag returned outside a get_wait hit");

  // The back end never takes from an empty queue.
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue read while empty");
`endif

endmodule

FILE: hdl/alce_front.sv
// Request front end: decodes each request and buffers it in a short queue.
module alce_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  alce_pkg::req_t req,
  input  logic          pop,
  output alce_pkg::head_t head
);
  import alce_pkg::*;

  op_t              q [QDEPTH];
  logic [QAW-1:0]   wp;
  logic [QAW-1:0]   rp;
  logic [QAW:0]     count;
  logic             push;
  logic             take;
  op_t              dec;

  always_comb begin
    dec.key        = req.key_tag;
    dec.now        = req.now;
    dec.handle     = '0;
    dec.wflag      = 1'b0;
    dec.upd_on_hit = 1'b0;
    case (req.kind)
      KIND_SET: begin
        dec.code       = OP_SET;
        dec.handle     = req.handle_in;
        dec.upd_on_hit = 1'b1;
      end
      KIND_GET:      dec.code = OP_GET;
      KIND_SET_WAIT: begin
        dec.code       = OP_SET_WAIT;
        dec.wflag      = req.wait_in;
        dec.upd_on_hit = ~req.wait_in;
      end
      KIND_GET_WAIT: dec.code = OP_GET_WAIT;
      KIND_REMOVE:   dec.code = OP_REMOVE;
      KIND_CLEAR:    dec.code = OP_CLEAR;
      default:       dec.code = OP_NOP;
    endcase
  end

  assign req_stall  = (count == (QAW+1)'(QDEPTH));
  assign push       = req_valid && !req_stall;
  assign take       = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.op    = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(take);
    end
  end

endmodule

FILE: hdl/alce_back.sv
// Execution back end: slot table, tag match, LRU victim scan and result register.
module alce_back #(
  parameter int ENTRIES = alce_pkg::ENTRIES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  alce_pkg::head_t head,
  output logic            pop,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output alce_pkg::rsp_t  rsp
);
  import alce_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {IDLE, LOOKUP, EXEC, SCAN, FILL} state_t;

  state_t               state;
  op_t                  op;
  logic [ENTRIES-1:0]   valid;
  logic [63:0]          keys [ENTRIES];
  logic [31:0]          handle_mem [ENTRIES];
  logic [31:0]          time_mem [ENTRIES];
  logic                 wait_mem [ENTRIES];

  logic                 hit;
  logic [IW-1:0]        hit_idx;
  logic                 has_empty;
  logic [IW-1:0]        empty_idx;
  logic [31:0]          handle_rd;
  logic                 wait_rd;
  logic [31:0]          time_rd;
  logic [IW-1:0]        cnt;
  logic [31:0]          best_time;
  logic [IW-1:0]        best_idx;

  logic [ENTRIES-1:0]   match;
  logic [IW-1:0]        m_idx;
  logic [IW-1:0]        e_idx;
  logic                 out_free;
  logic                 is_set;
  logic                 do_set;
  logic                 go_scan;
  logic                 emit;
  logic                 set_en;
  logic [IW-1:0]        set_idx;
  logic                 touch_en;
  logic                 rm_en;
  logic                 clr_en;
  logic                 t_we;
  logic [IW-1:0]        t_widx;
  logic [IW-1:0]        t_raddr;
  logic [31:0]          cand_time;
  logic [IW-1:0]        cand_idx;
  rsp_t                 rsp_next;

  always_comb begin
    m_idx = '0;
    e_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid[i] && (keys[i] == op.key);
      if (match[i]) begin
        m_idx = IW'(i);
      end
      if (!valid[i]) begin
        e_idx = IW'(i);
      end
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;
  assign is_set   = (op.code == OP_SET) || (op.code == OP_SET_WAIT);
  assign do_set   = is_set && (!hit || op.upd_on_hit);
  assign go_scan  = (state == EXEC) && out_free && do_set && !hit && !has_empty;
  assign emit     = ((state == EXEC) && out_free && !go_scan) || ((state == FILL) && out_free);
  assign pop      = head.valid && ((state == IDLE) || emit);

  always_comb begin
    set_en   = 1'b0;
    set_idx  = hit ? hit_idx : empty_idx;
    touch_en = 1'b0;
    rm_en    = 1'b0;
    clr_en   = 1'b0;
    if (state == FILL && out_free) begin
      set_en  = 1'b1;
      set_idx = best_idx;
    end else if (state == EXEC && out_free && !go_scan) begin
      set_en   = do_set;
      touch_en = (op.code == OP_GET) && hit;
      rm_en    = (op.code == OP_REMOVE) && hit;
      clr_en   = (op.code == OP_CLEAR);
    end
  end

  assign t_we   = set_en || touch_en;
  assign t_widx = set_en ? set_idx : hit_idx;

  always_comb begin
    if (state == SCAN) begin
      t_raddr = (cnt == LAST) ? cnt : cnt + 1'b1;
    end else begin
      t_raddr = '0;
    end
  end

  always_comb begin
    if (cnt == '0 || time_rd < best_time) begin
      cand_time = time_rd;
      cand_idx  = cnt;
    end else begin
      cand_time = best_time;
      cand_idx  = best_idx;
    end
  end

  always_comb begin
    rsp_next.hit        = hit && (op.code != OP_CLEAR) && (op.code != OP_NOP);
    rsp_next.handle_out = (op.code == OP_GET && hit) ? handle_rd : '0;
    rsp_next.wait_out   = (op.code == OP_GET_WAIT && hit) ? wait_rd : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (set_en) begin
      keys[set_idx]       <= op.key;
      handle_mem[set_idx] <= op.handle;
      wait_mem[set_idx]   <= op.wflag;
    end
    if (t_we) begin
      time_mem[t_widx] <= op.now;
    end
    handle_rd <= handle_mem[m_idx];
    wait_rd   <= wait_mem[m_idx];
    time_rd   <= time_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clr_en) begin
      valid <= '0;
    end else begin
      if (set_en) begin
        valid[set_idx] <= 1'b1;
      end
      if (rm_en) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (pop) begin
        op <= head.op;
      end
      unique case (state)
        IDLE: begin
          if (pop) begin
            state <= LOOKUP;
          end
        end
        LOOKUP: begin
          hit       <= |match;
          hit_idx   <= m_idx;
          has_empty <= ~&valid;
          empty_idx <= e_idx;
          state     <= EXEC;
        end
        EXEC: begin
          if (go_scan) begin
            cnt   <= '0;
            state <= SCAN;
          end else if (emit) begin
            state <= pop ? LOOKUP : IDLE;
          end
        end
        SCAN: begin
          best_time <= cand_time;
          best_idx  <= cand_idx;
          cnt       <= cnt + 1'b1;
          if (cnt == LAST) begin
            state <= FILL;
          end
        end
        FILL: begin
          if (emit) begin
            state <= pop ? LOOKUP : IDLE;
          end
        end
      endcase
    end
  end

endmodule
